// ----- hdl/aging_hash_cache_table_macros.svh -----
// Assertion helpers used by the top-level module.
`ifndef AGING_HASH_CACHE_TABLE_MACROS_SVH
`define AGING_HASH_CACHE_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AHCT_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define AHCT_ASSERT_NXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// ----- hdl/ahct_pkg.sv -----
`default_nettype none
package ahct_pkg;
	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	localparam logic [2:0] ST_HIT      = 3'd0;
	localparam logic [2:0] ST_MISS     = 3'd1;
	localparam logic [2:0] ST_INSERTED = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_TICK     = 3'd4;

	localparam logic [0:0] REG_IDLE_LIMIT   = 1'b0;
	localparam logic [0:0] REG_PRUNE_PERIOD = 1'b1;

	localparam logic [15:0] IDLE_LIMIT_RESET   = 16'd600;
	localparam logic [11:0] PRUNE_PERIOD_RESET = 12'd60;
	localparam logic [8:0]  COUNT_MAX          = 9'h1FF;

	typedef struct packed {
		logic [63:0] object_id;
		logic [15:0] frame_number;
		logic [31:0] handle;
		logic [31:0] last_used;
	} entry_t;

	typedef struct packed {
		logic idle;
		logic load;
		logic hash_step;
		logic rd;
		logic cmp;
		logic tick;
		logic srd;
		logic schk;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic pow2;
		logic op_tick;
		logic op_bad;
		logic hash_done;
		logic cmp_end;
		logic sweep_due;
		logic sweep_last;
		logic out_free;
	} stat_t;
endpackage
`default_nettype wire

// ----- hdl/ahct_ram.sv -----
`default_nettype none
module ahct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- hdl/ahct_ctrl.sv -----
`default_nettype none
module ahct_ctrl
	import ahct_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire stat_t st,
	output cmd_t       cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HASH = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_TICK = 3'd4;
	localparam logic [2:0] S_SRD  = 3'd5;
	localparam logic [2:0] S_SCHK = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					priority if (st.op_tick) state_d = S_TICK;
					else if (st.op_bad) state_d = S_DONE;
					else if (st.pow2) state_d = S_RD;
					else state_d = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (st.hash_done) state_d = S_RD;
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				cmd.cmp = 1'b1;
				state_d = st.cmp_end ? S_DONE : S_RD;
			end
			S_TICK: begin
				cmd.tick = 1'b1;
				state_d = st.sweep_due ? S_SRD : S_DONE;
			end
			S_SRD: begin
				cmd.srd = 1'b1;
				state_d = S_SCHK;
			end
			S_SCHK: begin
				cmd.schk = 1'b1;
				state_d = st.sweep_last ? S_DONE : S_SRD;
			end
			S_DONE: begin
				// hold the result until the output register frees up
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/ahct_dp.sv -----
`default_nettype none
module ahct_dp
	import ahct_pkg::*;
#(
	parameter int NUM_BUCKETS = 64,
	parameter int NUM_WAYS    = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output stat_t            st,
	input  wire logic [15:0] idle_limit,
	input  wire logic [11:0] prune_period,
	input  wire logic [1:0]  op,
	input  wire logic [63:0] object_id,
	input  wire logic [15:0] frame_number,
	input  wire logic [31:0] handle,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic [2:0]       status,
	output logic [31:0]      hit_handle,
	output logic [8:0]       removed_count
);
	localparam int TABLE = NUM_BUCKETS * NUM_WAYS;
	localparam int AW    = $clog2(TABLE);
	localparam int BW    = $clog2(NUM_BUCKETS);
	localparam int WIW   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam bit POW2  = ((1 << BW) == NUM_BUCKETS);

	logic [1:0]       op_q;
	logic [63:0]      obj_q;
	logic [15:0]      frm_q;
	logic [31:0]      hnd_q;
	logic [63:0]      sum_q;
	logic [BW-1:0]    rem_q, rem_d;
	logic [2:0]       hcnt_q;
	logic [BW-1:0]    bucket_q;
	logic [WIW-1:0]   way_q, free_q;
	logic             free_found_q;
	logic [AW-1:0]    idx_q;
	logic [TABLE-1:0] valid_q;
	logic [31:0]      sec_q;
	logic [11:0]      ticks_q, ticks_inc;
	logic [8:0]       count_q;
	logic [2:0]       res_status_q;
	logic [31:0]      res_hit_q;
	logic             out_valid_q;
	logic [63:0]      sum_d;

	logic [AW-1:0]    base_addr, way_addr, ins_addr, rd_addr;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	entry_t           ram_wdata, rdata;

	logic hit, last_way, slot_free, do_insert, aged;

	assign sum_d     = object_id + 64'(frame_number);
	assign ticks_inc = ticks_q + 12'd1;
	assign base_addr = AW'(bucket_q) * AW'(NUM_WAYS);
	assign way_addr  = base_addr + AW'(way_q);
	assign ins_addr  = base_addr + AW'(free_found_q ? free_q : way_q);
	assign rd_addr   = cmd.srd ? idx_q : way_addr;

	assign hit       = valid_q[way_addr] && rdata.object_id == obj_q
		&& rdata.frame_number == frm_q;
	assign last_way  = way_q == WIW'(NUM_WAYS - 1);
	assign slot_free = !valid_q[way_addr];
	assign do_insert = cmd.cmp && !hit && last_way && op_q == OP_INSERT
		&& (free_found_q || slot_free);
	assign aged      = valid_q[idx_q]
		&& (sec_q - rdata.last_used) >= {16'd0, idle_limit};

	// eight bits of the key sum per step, remainder kept below the bucket count
	always_comb begin
		logic [BW:0] t;
		rem_d = rem_q;
		for (int k = 0; k < 8; k++) begin
			t = {rem_d, sum_q[63-k]};
			if (t >= (BW+1)'(NUM_BUCKETS)) t = t - (BW+1)'(NUM_BUCKETS);
			rem_d = t[BW-1:0];
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = way_addr;
		ram_wdata = rdata;
		if (cmd.cmp && hit) begin
			ram_we = 1'b1;
			ram_wdata.last_used = sec_q;
		end else if (do_insert) begin
			ram_we    = 1'b1;
			ram_waddr = ins_addr;
			ram_wdata = '{object_id: obj_q, frame_number: frm_q,
				handle: hnd_q, last_used: sec_q};
		end
	end

	ahct_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd || cmd.srd),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q         <= op;
			obj_q        <= object_id;
			frm_q        <= frame_number;
			hnd_q        <= handle;
			sum_q        <= sum_d;
			rem_q        <= '0;
			hcnt_q       <= '0;
			bucket_q     <= sum_d[BW-1:0];
			way_q        <= '0;
			free_found_q <= 1'b0;
			res_status_q <= ST_MISS;
			res_hit_q    <= '0;
		end
		if (cmd.hash_step) begin
			rem_q  <= rem_d;
			sum_q  <= {sum_q[55:0], 8'd0};
			hcnt_q <= hcnt_q + 3'd1;
			if (hcnt_q == 3'd7) bucket_q <= rem_d;
		end
		if (cmd.cmp) begin
			if (!hit && !free_found_q && slot_free) begin
				free_found_q <= 1'b1;
				free_q       <= way_q;
			end
			if (!last_way) way_q <= way_q + WIW'(1);
			priority if (hit) begin
				res_status_q <= ST_HIT;
				res_hit_q    <= rdata.handle;
			end else if (last_way && do_insert) begin
				res_status_q <= ST_INSERTED;
			end else if (last_way && op_q == OP_INSERT) begin
				res_status_q <= ST_FULL;
			end else begin
				res_status_q <= ST_MISS;
			end
		end
		if (cmd.tick) begin
			res_status_q <= ST_TICK;
			idx_q        <= '0;
		end
		if (cmd.schk) idx_q <= idx_q + AW'(1);
		if (cmd.finish) begin
			status        <= res_status_q;
			hit_handle    <= res_hit_q;
			removed_count <= (res_status_q == ST_TICK) ? count_q : 9'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			sec_q       <= '0;
			ticks_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_insert) valid_q[ins_addr] <= 1'b1;
			if (cmd.tick) begin
				sec_q   <= sec_q + 32'd1;
				count_q <= '0;
				ticks_q <= (ticks_inc >= prune_period) ? 12'd0 : ticks_inc;
			end
			if (cmd.schk && aged) begin
				valid_q[idx_q] <= 1'b0;
				if (count_q != COUNT_MAX) count_q <= count_q + 9'd1;
			end
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign st.pow2       = POW2;
	assign st.op_tick    = op == OP_TICK;
	assign st.op_bad     = op != OP_TICK && op != OP_LOOKUP && op != OP_INSERT;
	assign st.hash_done  = hcnt_q == 3'd7;
	assign st.cmp_end    = hit || last_way;
	assign st.sweep_due  = ticks_inc >= prune_period;
	assign st.sweep_last = idx_q == AW'(TABLE - 1);
	assign st.out_free   = !out_valid_q || out_ready;
endmodule
`default_nettype wire

// ----- hdl/aging_hash_cache_table.sv -----
// Lookup/insert: reads the bucket's ways from the entry RAM one at a time, read then compare, until a hit
// or the last way; a hash pass (key sum mod bucket count) runs first when the bucket count is not a power of two.
// Tick: advances the seconds counter and, when the prune period is reached, sweeps every entry of the entry RAM.
// One item at a time; a result waits in the output register for out_ready.
// Reset: asynchronous, empties the table (valid flops), clears time and tick
// counters, loads idle_limit 600 and prune_period 60; no clearing pass.
`default_nettype none
`include "aging_hash_cache_table_macros.svh"
module aging_hash_cache_table
	import ahct_pkg::*;
#(
	parameter int NUM_BUCKETS = 64,
	parameter int NUM_WAYS    = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [63:0] object_id,
	input  wire logic [15:0] frame_number,
	input  wire logic [31:0] handle,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [31:0]      hit_handle,
	output logic [8:0]       removed_count
);
	logic [15:0] idle_limit_q;
	logic [11:0] prune_period_q;
	cmd_t        cmd;
	stat_t       st;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PRUNE_PERIOD) ? {20'd0, prune_period_q}
		: {16'd0, idle_limit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q   <= IDLE_LIMIT_RESET;
			prune_period_q <= PRUNE_PERIOD_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_IDLE_LIMIT) idle_limit_q <= pwdata[15:0];
			else prune_period_q <= pwdata[11:0];
		end
	end

	ahct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.st       (st),
		.cmd      (cmd)
	);

	ahct_dp #(.NUM_BUCKETS(NUM_BUCKETS), .NUM_WAYS(NUM_WAYS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.idle_limit    (idle_limit_q),
		.prune_period  (prune_period_q),
		.op            (op),
		.object_id     (object_id),
		.frame_number  (frame_number),
		.handle        (handle),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.status        (status),
		.hit_handle    (hit_handle),
		.removed_count (removed_count)
	);

	assign in_ready = cmd.idle;

	`AHCT_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "ready after accept")
	`AHCT_ASSERT_IMP(a_count_only_tick, clk, arst_n, out_valid && status != ST_TICK, removed_count == 9'd0, "count off tick")
	`AHCT_ASSERT_IMP(a_handle_only_hit, clk, arst_n, out_valid && status != ST_HIT, hit_handle == 32'd0, "handle off hit")
endmodule
`default_nettype wire

// ----- test/tb_aging_hash_cache_table.sv -----
`timescale 1ns / 1ps
module tb_aging_hash_cache_table;
	import ahct_pkg::*;

	localparam int NB = 64;
	localparam int NW = 4;
	localparam int TBL = NB * NW;
	localparam int WATCH_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] obj;
		logic [15:0] frm;
		logic [31:0] hnd;
	} req_t;

	typedef struct packed {
		logic [2:0]  st;
		logic [31:0] hh;
		logic [8:0]  rc;
	} rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = '0;
	logic [63:0] object_id = '0;
	logic [15:0] frame_number = '0;
	logic [31:0] handle = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [31:0] hit_handle;
	logic [8:0] removed_count;

	aging_hash_cache_table uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .object_id(object_id), .frame_number(frame_number), .handle(handle),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .hit_handle(hit_handle), .removed_count(removed_count)
	);

	always #6 clk = ~clk;

	// table mirror
	logic        m_valid [TBL];
	logic [63:0] m_obj [TBL];
	logic [15:0] m_frm [TBL];
	logic [31:0] m_hnd [TBL];
	logic [31:0] m_used [TBL];
	logic [31:0] now_sec;
	logic [11:0] tick_cnt;
	logic [15:0] cfg_idle;
	logic [11:0] cfg_period;

	req_t pending_items[$];
	rsp_t expected_rsp[$];
	int mismatches = 0;
	bit timed_out = 0;
	bit quiet_in = 0, quiet_out = 0;
	bit hold_send = 0;
	int watch = 0;

	// known keys, reused by random items to make hits
	logic [63:0] known_obj[$];
	logic [15:0] known_frm[$];

	function automatic rsp_t cache_predict(req_t r);
		rsp_t o;
		int base, slot, i;
		int unsigned cnt;
		logic [63:0] sum;
		o = '{st: ST_MISS, hh: '0, rc: '0};
		sum = r.obj + {48'd0, r.frm};
		base = int'(sum % NB) * NW;
		if (r.op == OP_LOOKUP || r.op == OP_INSERT) begin
			slot = -1;
			for (i = 0; i < NW; i++)
				if (slot < 0 && m_valid[base+i] && m_obj[base+i] == r.obj
						&& m_frm[base+i] == r.frm)
					slot = base + i;
			if (slot >= 0) begin
				m_used[slot] = now_sec;
				o.hh = m_hnd[slot];
				o.st = ST_HIT;
			end else if (r.op == OP_INSERT) begin
				o.st = ST_FULL;
				for (i = 0; i < NW; i++)
					if (o.st == ST_FULL && !m_valid[base+i]) begin
						m_valid[base+i] = 1'b1;
						m_obj[base+i] = r.obj;
						m_frm[base+i] = r.frm;
						m_hnd[base+i] = r.hnd;
						m_used[base+i] = now_sec;
						o.st = ST_INSERTED;
					end
			end
		end else if (r.op == OP_TICK) begin
			now_sec = now_sec + 1;
			tick_cnt = tick_cnt + 1;
			if (tick_cnt >= cfg_period) begin
				cnt = 0;
				for (i = 0; i < TBL; i++)
					if (m_valid[i] && (now_sec - m_used[i]) >= {16'd0, cfg_idle}) begin
						m_valid[i] = 1'b0;
						if (cnt < 511) cnt++;
					end
				o.rc = cnt[8:0];
				tick_cnt = '0;
			end
			o.st = ST_TICK;
		end
		return o;
	endfunction

	function automatic req_t rand_item(bit well_formed);
		req_t r;
		int k;
		r.op = 2'($urandom_range(0, 2));
		if (!well_formed) r.op = 2'($urandom_range(0, 3));
		r.hnd = $urandom;
		if (known_obj.size() > 0 && $urandom_range(0, 99) < 55) begin
			k = $urandom_range(0, known_obj.size() - 1);
			r.obj = known_obj[k];
			r.frm = known_frm[k];
		end else begin
			// narrow keys collide in buckets; wide keys toggle every bit
			if ($urandom_range(0, 1)) r.obj = {$urandom, $urandom};
			else r.obj = 64'($urandom_range(0, 600));
			r.frm = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 8));
			if (r.op == OP_INSERT && known_obj.size() < 400) begin
				known_obj.push_back(r.obj);
				known_frm.push_back(r.frm);
			end
		end
		return r;
	endfunction

	task automatic add_item(logic [1:0] o, logic [63:0] ob, logic [15:0] f, logic [31:0] h);
		pending_items.push_back('{op: o, obj: ob, frm: f, hnd: h});
	endtask

	task automatic cfg_write(logic [0:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_IDLE_LIMIT) cfg_idle = val[15:0];
		else cfg_period = val[11:0];
	endtask

	task automatic drain;
		while (pending_items.size() > 0 || expected_rsp.size() > 0 || in_valid)
			@(posedge clk);
		repeat (2 * TBL + 20) @(posedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (pending_items.size() > 0 && !hold_send
						&& (quiet_in || $urandom_range(0, 99) >= 6)) begin
					req_t r;
					r = pending_items.pop_front();
					op <= r.op; object_id <= r.obj; frame_number <= r.frm;
					handle <= r.hnd;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= quiet_out || $urandom_range(0, 99) >= 6;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_rsp.push_back(cache_predict('{op: op, obj: object_id,
					frm: frame_number, hnd: handle}));
			if (out_valid && out_ready) begin
				if (expected_rsp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result st=%0d hh=%h rc=%0d",
							status, hit_handle, removed_count);
				end else begin
					rsp_t e;
					e = expected_rsp.pop_front();
					if (e.st !== status || e.hh !== hit_handle || e.rc !== removed_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp st=%0d hh=%h rc=%0d, got st=%0d hh=%h rc=%0d",
								e.st, e.hh, e.rc, status, hit_handle, removed_count);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				watch <= 0;
			else
				watch <= watch + 1;
			if (watch > WATCH_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		int i, p;
		req_t r;
		for (i = 0; i < TBL; i++) begin
			m_valid[i] = 0; m_obj[i] = '0; m_frm[i] = '0; m_hnd[i] = '0; m_used[i] = '0;
		end
		now_sec = '0; tick_cnt = '0;
		cfg_idle = IDLE_LIMIT_RESET; cfg_period = PRUNE_PERIOD_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		cfg_write(REG_IDLE_LIMIT, 32'd3);
		cfg_write(REG_PRUNE_PERIOD, 32'd1);

		// directed: edges, hits, duplicate insert, full bucket, unused op, sweeps
		add_item(OP_LOOKUP, 64'd0, 16'd0, 32'd0);
		add_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
		add_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 32'd0);
		add_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 32'h1234_5678);
		for (i = 0; i < 5; i++)
			add_item(OP_INSERT, 64'(i * NB), 16'd0, 32'(i + 100));
		add_item(OP_LOOKUP, 64'(2 * NB), 16'd0, 32'd0);
		add_item(OP_INSERT, 64'd0, 16'd64, 32'd7);
		add_item(2'd3, 64'hAAAA_5555_AAAA_5555, 16'h5A5A, 32'hDEAD_BEEF);
		add_item(OP_TICK, 64'd0, 16'd0, 32'd0);
		add_item(OP_LOOKUP, 64'd0, 16'd0, 32'd0);
		add_item(OP_TICK, 64'd0, 16'd0, 32'd0);
		add_item(OP_TICK, 64'd0, 16'd0, 32'd0);
		add_item(OP_TICK, 64'd0, 16'd0, 32'd0);
		add_item(OP_LOOKUP, 64'd0, 16'd0, 32'd0);
		drain();

		cfg_write(REG_IDLE_LIMIT, 32'd0);
		add_item(OP_INSERT, 64'd5, 16'd1, 32'd9);
		add_item(OP_TICK, 64'd0, 16'd0, 32'd0);
		drain();

		// random phases under several settings
		for (p = 0; p < 5; p++) begin
			case (p)
				0: begin cfg_write(REG_IDLE_LIMIT, 32'd20); cfg_write(REG_PRUNE_PERIOD, 32'd5); end
				1: begin cfg_write(REG_IDLE_LIMIT, 32'd65535); cfg_write(REG_PRUNE_PERIOD, 32'd3600); end
				2: begin cfg_write(REG_IDLE_LIMIT, 32'd1); cfg_write(REG_PRUNE_PERIOD, 32'd2); end
				3: begin cfg_write(REG_IDLE_LIMIT, 32'd60); cfg_write(REG_PRUNE_PERIOD, 32'd0); end
				default: begin
					cfg_write(REG_IDLE_LIMIT, $urandom_range(5, 200));
					cfg_write(REG_PRUNE_PERIOD, $urandom_range(1, 40));
				end
			endcase
			quiet_in = (p == 2); quiet_out = (p == 2);
			for (i = 0; i < 300; i++) begin
				r = rand_item($urandom_range(0, 99) < 95);
				pending_items.push_back(r);
			end
			if (p == 1) begin
				// let the items in flight finish before sending more
				while (pending_items.size() > 150) @(posedge clk);
				hold_send = 1;
				while (expected_rsp.size() > 0 || in_valid) @(posedge clk);
				hold_send = 0;
			end
			drain();
		end

		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
